/* rtl/irpd_pkg.sv */
`default_nettype none

package irpd_pkg;

    // Fixed width of the command field on the input channel
    localparam int unsigned CMD_W  = 4;
    localparam int unsigned TICK_W = 8;

    // Register map, index = paddr / 4
    typedef enum logic [1:0] {
        REG_HEADER_MARK = 2'd0,
        REG_ZERO_MARK   = 2'd1,
        REG_ONE_MARK    = 2'd2,
        REG_SPACE       = 2'd3
    } reg_idx_t;

    localparam logic [TICK_W-1:0] HEADER_MARK_RST = 8'd32;
    localparam logic [TICK_W-1:0] ZERO_MARK_RST   = 8'd16;
    localparam logic [TICK_W-1:0] ONE_MARK_RST    = 8'd64;
    localparam logic [TICK_W-1:0] SPACE_RST       = 8'd38;

    typedef struct packed {
        logic [TICK_W-1:0] header_mark_ticks;
        logic [TICK_W-1:0] zero_mark_ticks;
        logic [TICK_W-1:0] one_mark_ticks;
        logic [TICK_W-1:0] space_ticks;
    } cfg_t;

    typedef struct packed {
        logic ir_level;
        logic busy_res;
        logic frame_done;
        logic start_taken;
    } result_t;

endpackage

`default_nettype wire

/* rtl/irpd_seq.sv */
`default_nettype none

module irpd_seq #(
    parameter int unsigned COMMAND_BITS = 4
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      accept,
    input  wire logic                      func,
    input  wire logic [irpd_pkg::CMD_W-1:0] command,
    input  wire irpd_pkg::cfg_t            cfg,
    output irpd_pkg::result_t              result
);
    import irpd_pkg::*;

    localparam int unsigned IdxW = $clog2(COMMAND_BITS + 1);

    logic                    sending_reg, sending_next;
    logic                    in_space_reg, in_space_next;
    logic [TICK_W-1:0]       tick_reg, tick_next;
    logic [IdxW-1:0]         idx_reg, idx_next;
    logic [COMMAND_BITS-1:0] code_reg, code_next;
    logic                    pin_reg, pin_next;

    logic [TICK_W-1:0]       tick_inc;
    logic [TICK_W-1:0]       mark_len;
    logic                    done;
    logic                    taken;

    assign tick_inc = tick_reg + TICK_W'(1);

    // Code bits shift left after each data bit, so the current bit is the MSB
    always_comb begin
        if (idx_reg == '0) begin
            mark_len = cfg.header_mark_ticks;
        end else if (code_reg[COMMAND_BITS-1]) begin
            mark_len = cfg.one_mark_ticks;
        end else begin
            mark_len = cfg.zero_mark_ticks;
        end
    end

    always_comb begin
        sending_next  = sending_reg;
        in_space_next = in_space_reg;
        tick_next     = tick_reg;
        idx_next      = idx_reg;
        code_next     = code_reg;
        pin_next      = pin_reg;
        done          = 1'b0;
        taken         = 1'b0;
        if (func) begin
            if (!sending_reg) begin
                code_next     = COMMAND_BITS'(command);
                sending_next  = 1'b1;
                in_space_next = 1'b0;
                tick_next     = '0;
                idx_next      = '0;
                taken         = 1'b1;
            end
        end else if (sending_reg) begin
            tick_next = tick_inc;
            if (!in_space_reg) begin
                pin_next = ~pin_reg;
                if (tick_inc == mark_len) begin
                    in_space_next = 1'b1;
                    tick_next     = '0;
                end
            end else begin
                pin_next = 1'b0;
                if (tick_inc == cfg.space_ticks) begin
                    in_space_next = 1'b0;
                    tick_next     = '0;
                    if (idx_reg == IdxW'(COMMAND_BITS)) begin
                        sending_next = 1'b0;
                        idx_next     = '0;
                        done         = 1'b1;
                    end else begin
                        idx_next = idx_reg + IdxW'(1);
                        if (idx_reg != '0) begin
                            code_next = code_reg << 1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sending_reg  <= 1'b0;
            in_space_reg <= 1'b0;
            tick_reg     <= '0;
            idx_reg      <= '0;
            code_reg     <= '0;
            pin_reg      <= 1'b0;
        end else if (accept) begin
            sending_reg  <= sending_next;
            in_space_reg <= in_space_next;
            tick_reg     <= tick_next;
            idx_reg      <= idx_next;
            code_reg     <= code_next;
            pin_reg      <= pin_next;
        end
    end

    assign result.ir_level    = pin_next;
    assign result.busy_res    = sending_next;
    assign result.frame_done  = done;
    assign result.start_taken = taken;

endmodule

`default_nettype wire

/* rtl/ir_pulse_distance_transmitter_unit.sv */
// The result of an accepted input transaction is registered for the m_ side in the cycle after.
// One transaction per cycle unless m_ready stalls; one compare per tick, toggling in a mark.
// s_ready stays high while the result register is empty or being drained in the same cycle.
// Reset (aresetn low, synchronous): frame idle, pin low, result register empty,
// length registers back to 32 / 16 / 64 / 38 ticks.
`default_nettype none

module ir_pulse_distance_transmitter_unit #(
    parameter int unsigned COMMAND_BITS = 4
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // Input channel
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_func,
    input  wire logic [irpd_pkg::CMD_W-1:0] s_command,
    // Result channel
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_ir_level,
    output logic                            m_busy_res,
    output logic                            m_frame_done,
    output logic                            m_start_taken,
    // Configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [3:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import irpd_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_sel;
    logic     cfg_wr;

    logic     s_accept;
    result_t  result_next;
    result_t  result_reg;
    logic     m_valid_reg;

    // ------------------------------------------------------------------
    // Configuration registers: always ready, write on the access phase
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_mark_ticks <= HEADER_MARK_RST;
            cfg_reg.zero_mark_ticks   <= ZERO_MARK_RST;
            cfg_reg.one_mark_ticks    <= ONE_MARK_RST;
            cfg_reg.space_ticks       <= SPACE_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_HEADER_MARK: cfg_reg.header_mark_ticks <= pwdata[TICK_W-1:0];
                REG_ZERO_MARK:   cfg_reg.zero_mark_ticks   <= pwdata[TICK_W-1:0];
                REG_ONE_MARK:    cfg_reg.one_mark_ticks    <= pwdata[TICK_W-1:0];
                REG_SPACE:       cfg_reg.space_ticks       <= pwdata[TICK_W-1:0];
                default:         ;
            endcase
        end
    end

    // Read back zero-extended; the byte lane bits of paddr are ignored
    always_comb begin
        unique case (reg_sel)
            REG_HEADER_MARK: prdata = 32'(cfg_reg.header_mark_ticks);
            REG_ZERO_MARK:   prdata = 32'(cfg_reg.zero_mark_ticks);
            REG_ONE_MARK:    prdata = 32'(cfg_reg.one_mark_ticks);
            REG_SPACE:       prdata = 32'(cfg_reg.space_ticks);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: take a new transaction whenever the result slot is free
    // or its content leaves in this cycle.
    // ------------------------------------------------------------------
    assign s_ready  = ~m_valid_reg | m_ready;
    assign s_accept = s_valid & s_ready;

    // Frame sequencer: state advances only on an accepted transaction
    irpd_seq #(
        .COMMAND_BITS (COMMAND_BITS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .func    (s_func),
        .command (s_command),
        .cfg     (cfg_reg),
        .result  (result_next)
    );

    // Result register: load on accept, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Payload holds while stalled; no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_ir_level    = result_reg.ir_level;
    assign m_busy_res    = result_reg.busy_res;
    assign m_frame_done  = result_reg.frame_done;
    assign m_start_taken = result_reg.start_taken;

endmodule

`default_nettype wire

/* rtl/irpd_checker.sv */
`default_nettype none

module irpd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_ir_level,
    input wire logic        m_busy_res,
    input wire logic        m_frame_done,
    input wire logic        m_start_taken
);

    // An accepted start leaves the frame running with the pin still low
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_start_taken) |-> (m_busy_res && !m_ir_level && !m_frame_done))
        else $error("accepted start without busy frame or with pin high");

    // Outside a frame the pin is low
    a_idle_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_busy_res) |-> !m_ir_level)
        else $error("pin high while idle");

    // Frame end marks the idle state
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_done) |-> !m_busy_res)
        else $error("frame done while still busy");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_ir_level) && $stable(m_busy_res)
            && $stable(m_frame_done) && $stable(m_start_taken)))
        else $error("stalled result changed");

endmodule

bind ir_pulse_distance_transmitter_unit irpd_checker u_irpd_checker (.*);

`default_nettype wire
